FILE: rtl/hufd_pkg.sv
`default_nettype none

package hufd_pkg;

  localparam int unsigned NodeCountDef = 512;
  localparam int unsigned MaxCodeLen   = 32;

  // fixed field widths
  localparam int unsigned SymW  = 8;
  localparam int unsigned CodeW = 32;
  localparam int unsigned LenW  = 6;
  localparam int unsigned ByteW = 8;
  localparam int unsigned CntW  = 4;

  // longest code an insert may carry
  localparam int unsigned CodeLimit = (MaxCodeLen < CodeW) ? MaxCodeLen : CodeW;

  localparam int unsigned InDataW  = 64;
  localparam int unsigned OutDataW = 16;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DECODE = 2'd2
  } hufd_cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_CONFLICT = 2'd2,
    ST_MISSING  = 2'd3
  } hufd_status_e;

  typedef struct packed {
    logic              last;
    hufd_status_e      status;
    logic              has_sym;
    logic [SymW-1:0]   sym;
  } hufd_res_t;

  typedef struct packed {
    logic wr_en;
    logic root_clr;
  } hufd_wr_t;

endpackage

`default_nettype wire

FILE: rtl/hufd_store.sv
`default_nettype none

module hufd_store import hufd_pkg::*; #(
  parameter int unsigned NodeCount = NodeCountDef,
  localparam int unsigned PtrW = $clog2(NodeCount),
  localparam int unsigned EntW = 2 * PtrW + SymW
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire hufd_wr_t        ctl_i,
  input  wire logic [PtrW-1:0] waddr_i,
  input  wire logic [EntW-1:0] wdata_i,
  input  wire logic [PtrW-1:0] raddr_i,
  output logic      [EntW-1:0] rdata_o,
  output logic      [EntW-1:0] root_o
);

  // entry layout: {left child, right child, symbol}
  logic [EntW-1:0] mem_q [NodeCount];
  logic [EntW-1:0] rdata_q;
  logic [EntW-1:0] root_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en && (waddr_i != '0)) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  // the root lives in flops so that reset and clear empty the tree at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= '0;
    end else if (ctl_i.root_clr) begin
      root_q <= '0;
    end else if (ctl_i.wr_en && (waddr_i == '0)) begin
      root_q <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;
  assign root_o  = root_q;

endmodule

`default_nettype wire

FILE: rtl/hufd_out.sv
`default_nettype none

module hufd_out import hufd_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire hufd_res_t res_i,
  output logic           free_o,
  output logic           valid_o,
  input  wire logic      ready_i,
  output hufd_res_t      res_o
);

  logic      valid_q;
  hufd_res_t res_q;

  assign free_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

FILE: rtl/hufd_walker.sv
`default_nettype none

module hufd_walker import hufd_pkg::*; #(
  parameter int unsigned NodeCount = NodeCountDef,
  localparam int unsigned PtrW = $clog2(NodeCount),
  localparam int unsigned EntW = 2 * PtrW + SymW
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [1:0]       cmd_i,
  input  wire logic [SymW-1:0]  sym_i,
  input  wire logic [CodeW-1:0] code_i,
  input  wire logic [LenW-1:0]  len_i,
  input  wire logic [ByteW-1:0] byte_i,
  input  wire logic [CntW-1:0]  cnt_i,
  output hufd_wr_t              ctl_o,
  output logic      [PtrW-1:0]  waddr_o,
  output logic      [EntW-1:0]  wdata_o,
  output logic      [PtrW-1:0]  raddr_o,
  input  wire logic [EntW-1:0]  rdata_i,
  input  wire logic [EntW-1:0]  root_i,
  output logic                  push_o,
  output hufd_res_t             res_o,
  input  wire logic             out_free_i
);

  localparam int unsigned FreeW = $clog2(NodeCount + 1);
  localparam int unsigned CmpW  = ((FreeW > LenW) ? FreeW : LenW) + 1;
  localparam int unsigned TapW  = $clog2(CodeW);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_FOLLOW = 9'b000000010,
    S_ROOM   = 9'b000000100,
    S_MAKE   = 9'b000001000,
    S_RESULT = 9'b000010000,
    S_STEP   = 9'b000100000,
    S_CHECK  = 9'b001000000,
    S_MISS   = 9'b010000000,
    S_END    = 9'b100000000
  } walk_state_e;

  walk_state_e      state_q, state_d;
  logic [PtrW-1:0]  node_q, node_d;
  logic [PtrW-1:0]  walk_q, walk_d;
  logic [PtrW-1:0]  cand_q, cand_d;
  logic [EntW-1:0]  ent_q, ent_d;
  logic [FreeW-1:0] free_q, free_d;
  logic [CodeW-1:0] code_q, code_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [LenW-1:0]  depth_q, depth_d;
  logic [SymW-1:0]  sym_q, sym_d;
  logic [ByteW-1:0] byte_q, byte_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  hufd_status_e     status_q, status_d;
  logic             hold_v_q, hold_v_d;
  logic [SymW-1:0]  hold_sym_q, hold_sym_d;

  logic             accept;
  logic [LenW-1:0]  len_m1;
  logic             tap;
  logic [EntW-1:0]  cur_ins;
  logic             ins_leaf;
  logic [PtrW-1:0]  nx_ins;
  logic [LenW-1:0]  need;
  logic [CmpW-1:0]  room;
  logic [PtrW-1:0]  nn;
  logic [EntW-1:0]  e_dec;
  logic [PtrW-1:0]  nx_dec;
  logic             dec_bad;
  logic             chk_leaf;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // code path bits leave at position len-1 of a left-shifting register
  assign len_m1 = len_q - LenW'(1);
  assign tap    = code_q[len_m1[TapW-1:0]];

  assign cur_ins  = (node_q == '0) ? root_i : rdata_i;
  assign ins_leaf = (node_q != '0) && (cur_ins[EntW-1 -: PtrW] == '0) &&
                    (cur_ins[SymW +: PtrW] == '0);
  assign nx_ins   = tap ? cur_ins[SymW +: PtrW] : cur_ins[EntW-1 -: PtrW];

  assign need = len_q - depth_q;
  assign room = CmpW'(NodeCount) - CmpW'(free_q);
  assign nn   = free_q[PtrW-1:0];

  assign e_dec    = (state_q == S_CHECK || walk_q != '0) ? rdata_i : root_i;
  assign nx_dec   = byte_q[ByteW-1] ? e_dec[SymW +: PtrW] : e_dec[EntW-1 -: PtrW];
  assign dec_bad  = (nx_dec == '0) || ((PtrW+1)'(nx_dec) >= (PtrW+1)'(NodeCount));
  assign chk_leaf = (rdata_i[EntW-1 -: PtrW] == '0) && (rdata_i[SymW +: PtrW] == '0);

  always_comb begin
    state_d    = state_q;
    node_d     = node_q;
    walk_d     = walk_q;
    cand_d     = cand_q;
    ent_d      = ent_q;
    free_d     = free_q;
    code_d     = code_q;
    len_d      = len_q;
    depth_d    = depth_q;
    sym_d      = sym_q;
    byte_d     = byte_q;
    cnt_d      = cnt_q;
    status_d   = status_q;
    hold_v_d   = hold_v_q;
    hold_sym_d = hold_sym_q;
    ctl_o      = '0;
    waddr_o    = node_q;
    wdata_o    = '0;
    raddr_o    = walk_q;
    push_o     = 1'b0;
    res_o      = '{last: 1'b1, status: status_q, has_sym: 1'b0, sym: '0};

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (hufd_cmd_e'(cmd_i))
            CMD_CLEAR: begin
              ctl_o.root_clr = 1'b1;
              free_d   = FreeW'(1);
              walk_d   = '0;
              status_d = ST_OK;
              state_d  = S_RESULT;
            end
            CMD_INSERT: begin
              node_d  = '0;
              code_d  = code_i;
              len_d   = len_i;
              depth_d = '0;
              sym_d   = sym_i;
              if (len_i == '0 || len_i > LenW'(CodeLimit)) begin
                status_d = ST_CONFLICT;
                state_d  = S_RESULT;
              end else begin
                state_d = S_FOLLOW;
              end
            end
            CMD_DECODE: begin
              byte_d  = byte_i;
              cnt_d   = (cnt_i > CntW'(ByteW)) ? CntW'(ByteW) : cnt_i;
              state_d = S_STEP;
            end
            default: begin
              status_d = ST_OK;
              state_d  = S_RESULT;
            end
          endcase
        end
      end

      // follow the part of the code path that already exists
      S_FOLLOW: begin
        raddr_o = nx_ins;
        if (depth_q == len_q || ins_leaf) begin
          status_d = ST_CONFLICT;
          state_d  = S_RESULT;
        end else if (nx_ins == '0) begin
          ent_d   = cur_ins;
          state_d = S_ROOM;
        end else begin
          node_d  = nx_ins;
          depth_d = depth_q + LenW'(1);
          code_d  = {code_q[CodeW-2:0], 1'b0};
        end
      end

      S_ROOM: begin
        if (CmpW'(free_q) > CmpW'(NodeCount) || CmpW'(need) > room) begin
          status_d = ST_FULL;
          state_d  = S_RESULT;
        end else begin
          state_d = S_MAKE;
        end
      end

      // one new node per cycle; the parent is rewritten with its new child
      S_MAKE: begin
        ctl_o.wr_en = 1'b1;
        if (depth_q != len_q) begin
          wdata_o = tap ? {ent_q[EntW-1 -: PtrW], nn, ent_q[SymW-1:0]}
                        : {nn, ent_q[SymW +: PtrW], ent_q[SymW-1:0]};
          free_d  = free_q + FreeW'(1);
          node_d  = nn;
          ent_d   = '0;
          depth_d = depth_q + LenW'(1);
          code_d  = {code_q[CodeW-2:0], 1'b0};
        end else begin
          wdata_o  = {{(2*PtrW){1'b0}}, sym_q};
          status_d = ST_OK;
          state_d  = S_RESULT;
        end
      end

      S_RESULT: begin
        if (out_free_i) begin
          push_o  = 1'b1;
          state_d = S_IDLE;
        end
      end

      S_STEP, S_CHECK: begin
        if (state_q == S_CHECK) begin
          raddr_o = cand_q;
        end
        if (state_q == S_CHECK && chk_leaf) begin
          // a symbol is held back until it is known whether it ends the request
          if (!hold_v_q || out_free_i) begin
            push_o     = hold_v_q;
            res_o      = '{last: 1'b0, status: ST_OK, has_sym: 1'b1, sym: hold_sym_q};
            hold_v_d   = 1'b1;
            hold_sym_d = rdata_i[SymW-1:0];
            walk_d     = '0;
            state_d    = S_STEP;
          end
        end else begin
          if (state_q == S_CHECK) begin
            walk_d = cand_q;
          end
          if (cnt_q == '0) begin
            state_d = S_END;
          end else if (dec_bad) begin
            walk_d  = '0;
            state_d = S_MISS;
          end else begin
            raddr_o = nx_dec;
            cand_d  = nx_dec;
            byte_d  = {byte_q[ByteW-2:0], 1'b0};
            cnt_d   = cnt_q - CntW'(1);
            state_d = S_CHECK;
          end
        end
      end

      S_MISS: begin
        if (out_free_i) begin
          push_o = 1'b1;
          if (hold_v_q) begin
            res_o    = '{last: 1'b0, status: ST_OK, has_sym: 1'b1, sym: hold_sym_q};
            hold_v_d = 1'b0;
          end else begin
            res_o   = '{last: 1'b1, status: ST_MISSING, has_sym: 1'b0, sym: '0};
            state_d = S_IDLE;
          end
        end
      end

      S_END: begin
        if (out_free_i) begin
          push_o   = 1'b1;
          res_o    = '{last: 1'b1, status: ST_OK, has_sym: hold_v_q,
                       sym: (hold_v_q ? hold_sym_q : '0)};
          hold_v_d = 1'b0;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      walk_q   <= '0;
      free_q   <= FreeW'(1);
      hold_v_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      walk_q   <= walk_d;
      free_q   <= free_d;
      hold_v_q <= hold_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q     <= node_d;
    cand_q     <= cand_d;
    ent_q      <= ent_d;
    code_q     <= code_d;
    len_q      <= len_d;
    depth_q    <= depth_d;
    sym_q      <= sym_d;
    byte_q     <= byte_d;
    cnt_q      <= cnt_d;
    status_q   <= status_d;
    hold_sym_q <= hold_sym_d;
  end

`ifndef ASSERT_OFF
  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= FreeW'(NodeCount))
    else $error("node allocator ran past the store");

  a_make_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MAKE && depth_q != len_q) |-> (free_q < FreeW'(NodeCount)))
    else $error("node created without room");

  a_hold_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_v_q |-> (state_q == S_STEP || state_q == S_CHECK ||
                  state_q == S_MISS || state_q == S_END))
    else $error("held symbol outside a decode request");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> out_free_i)
    else $error("result pushed into a full output register");
`endif

endmodule

`default_nettype wire

FILE: rtl/huffman_tree_decoder.sv
`default_nettype none

// Huffman code-tree decoder. A request on the slave side is a clear (empty the
// tree), an insert (add one code path, symbol at its leaf) or a decode (walk
// the valid top bits of one coded byte MSB-first, one node store read per bit,
// emitting a symbol at each leaf). Each request gives one result, a decode
// one per decoded symbol (at least one), plus one when a path is missing; the
// final one is marked by tlast. The walk position carries over between decode
// requests. Only the root is held in flops, so reset and clear take effect at
// once with no clearing pass. Existing nodes of an insert are followed one per
// cycle and new nodes are written one per cycle through the single write port;
// a decode reads one node per bit through the single registered read port of
// the node store. Results pass through an output register, so the next request
// is taken while the last result waits; a stalled master side holds the walk.
module huffman_tree_decoder import hufd_pkg::*; #(
  parameter int unsigned NodeCount = NodeCountDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // symbol[7:0], code_bits[39:8], code_len[45:40], data_byte[53:46],
  // bit_count[57:54], zero fill above
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,
  // cmd[1:0]
  input  wire logic [1:0]          s_axis_tuser_i,
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // out_symbol[7:0], status[9:8], zero fill above
  output logic      [OutDataW-1:0] m_axis_tdata_o,
  // has_symbol
  output logic                     m_axis_tuser_o,
  output logic                     m_axis_tlast_o
);

  localparam int unsigned PtrW = $clog2(NodeCount);
  localparam int unsigned EntW = 2 * PtrW + SymW;

  hufd_wr_t        st_ctl;
  logic [PtrW-1:0] st_waddr;
  logic [EntW-1:0] st_wdata;
  logic [PtrW-1:0] st_raddr;
  logic [EntW-1:0] st_rdata;
  logic [EntW-1:0] st_root;
  logic            push;
  hufd_res_t       push_res;
  logic            out_free;
  hufd_res_t       out_res;

  hufd_walker #(
    .NodeCount (NodeCount)
  ) u_walker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .cmd_i      (s_axis_tuser_i),
    .sym_i      (s_axis_tdata_i[7:0]),
    .code_i     (s_axis_tdata_i[39:8]),
    .len_i      (s_axis_tdata_i[45:40]),
    .byte_i     (s_axis_tdata_i[53:46]),
    .cnt_i      (s_axis_tdata_i[57:54]),
    .ctl_o      (st_ctl),
    .waddr_o    (st_waddr),
    .wdata_o    (st_wdata),
    .raddr_o    (st_raddr),
    .rdata_i    (st_rdata),
    .root_i     (st_root),
    .push_o     (push),
    .res_o      (push_res),
    .out_free_i (out_free)
  );

  hufd_store #(
    .NodeCount (NodeCount)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (st_ctl),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata),
    .root_o  (st_root)
  );

  hufd_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .res_i   (push_res),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .res_o   (out_res)
  );

  assign m_axis_tdata_o = {{(OutDataW - SymW - 2){1'b0}}, out_res.status, out_res.sym};
  assign m_axis_tuser_o = out_res.has_sym;
  assign m_axis_tlast_o = out_res.last;

endmodule

`default_nettype wire
